### rtl/dcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcg_pkg
// Types, constants and helper functions shared by the descriptor checksum
// generator: GF(32) polymod round, input charset lookup, output alphabet.
// ----------------------------------------------------------------------------
package dcg_pkg;

  localparam int unsigned ResidueW = 40;
  localparam int unsigned SymW     = 5;
  localparam int unsigned CheckLen = 8;

  localparam logic [ResidueW-1:0] GEN0 = 40'hF5DEE51989;
  localparam logic [ResidueW-1:0] GEN1 = 40'hA9FDCA3312;
  localparam logic [ResidueW-1:0] GEN2 = 40'h1BAB10E32D;
  localparam logic [ResidueW-1:0] GEN3 = 40'h3706B1677A;
  localparam logic [ResidueW-1:0] GEN4 = 40'h644D626FFD;

  localparam logic [ResidueW-1:0] RESIDUE_INIT = 40'h1;

  // bech32 alphabet, indexed by symbol value
  localparam logic [7:0] OUT_ALPHABET [CheckLen*4] = '{
    8'h71, 8'h70, 8'h7A, 8'h72, 8'h79, 8'h39, 8'h78, 8'h38,
    8'h67, 8'h66, 8'h32, 8'h74, 8'h76, 8'h64, 8'h77, 8'h30,
    8'h73, 8'h33, 8'h6A, 8'h6E, 8'h35, 8'h34, 8'h6B, 8'h68,
    8'h63, 8'h65, 8'h36, 8'h6D, 8'h75, 8'h61, 8'h37, 8'h6C
  };

  typedef struct packed {
    logic       ok;
    logic [6:0] pos;
  } sym_class_t;

  // Finished descriptor handed from the front to the back
  typedef struct packed {
    logic [ResidueW-1:0] residue;
    logic [SymW-1:0]     class_group;
    logic                flush;
    logic                err;
  } desc_t;

  // One polymod round: shift in a 5-bit symbol
  function automatic logic [ResidueW-1:0] fold_symbol(input logic [ResidueW-1:0] r,
                                                       input logic [SymW-1:0] sym);
    logic [SymW-1:0]     top;
    logic [ResidueW-1:0] n;
    top = r[ResidueW-1 -: SymW];
    n   = {r[ResidueW-SymW-1:0], sym};
    if (top[0]) n = n ^ GEN0;
    if (top[1]) n = n ^ GEN1;
    if (top[2]) n = n ^ GEN2;
    if (top[3]) n = n ^ GEN3;
    if (top[4]) n = n ^ GEN4;
    return n;
  endfunction

  // Position of a byte in the 95-symbol input charset
  function automatic sym_class_t classify(input logic [7:0] ch);
    sym_class_t c;
    logic [7:0] p;
    p = 8'h00;
    c.ok = 1'b1;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      p = ch - 8'd48;
    end else if (ch >= 8'h61 && ch <= 8'h68) begin
      p = ch - 8'd79;
    end else if (ch >= 8'h49 && ch <= 8'h5A) begin
      p = ch - 8'd41;
    end else if (ch >= 8'h69 && ch <= 8'h7A) begin
      p = ch - 8'd41;
    end else if (ch >= 8'h41 && ch <= 8'h48) begin
      p = ch + 8'd17;
    end else begin
      case (ch)
        8'h28: p = 8'd10;
        8'h29: p = 8'd11;
        8'h5B: p = 8'd12;
        8'h5D: p = 8'd13;
        8'h2C: p = 8'd14;
        8'h27: p = 8'd15;
        8'h2F: p = 8'd16;
        8'h2A: p = 8'd17;
        8'h40: p = 8'd26;
        8'h3A: p = 8'd27;
        8'h24: p = 8'd28;
        8'h25: p = 8'd29;
        8'h7B: p = 8'd30;
        8'h7D: p = 8'd31;
        8'h26: p = 8'd50;
        8'h2B: p = 8'd51;
        8'h2D: p = 8'd52;
        8'h2E: p = 8'd53;
        8'h3B: p = 8'd54;
        8'h3C: p = 8'd55;
        8'h3D: p = 8'd56;
        8'h3E: p = 8'd57;
        8'h3F: p = 8'd58;
        8'h21: p = 8'd59;
        8'h5E: p = 8'd60;
        8'h5F: p = 8'd61;
        8'h7C: p = 8'd62;
        8'h7E: p = 8'd63;
        8'h60: p = 8'd90;
        8'h23: p = 8'd91;
        8'h22: p = 8'd92;
        8'h5C: p = 8'd93;
        8'h20: p = 8'd94;
        default: c.ok = 1'b0;
      endcase
    end
    c.pos = p[6:0];
    return c;
  endfunction

endpackage

### rtl/dcg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcg_front
// Takes one character a cycle (a final one waits while the queue is full),
// folds it and its class into the running residue, and hands the finished
// descriptor state to the queue.
module dcg_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     char_code,
  input  logic           last_char,
  output logic           push,
  output dcg_pkg::desc_t push_desc,
  input  logic           q_full
);
  import dcg_pkg::*;

  logic [ResidueW-1:0] residue, residue_next, r1;
  logic [SymW-1:0]     class_group, class_group_next;
  logic [1:0]          group_count, group_count_next;
  logic                error_seen, error_seen_next;
  logic [6:0]          cg_times3;
  sym_class_t          sc;
  logic                accept;

  // only a final character needs room in the queue
  assign in_stall = last_char & q_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    sc               = classify(char_code);
    cg_times3        = {1'b0, class_group, 1'b0} + {2'b00, class_group} + {5'b0, sc.pos[6:5]};
    r1               = fold_symbol(residue, sc.pos[4:0]);
    residue_next     = residue;
    class_group_next = class_group;
    group_count_next = group_count;
    error_seen_next  = error_seen;
    if (!sc.ok) begin
      error_seen_next = 1'b1;
    end else if (group_count == 2'd2) begin
      // third character of a group: fold the class group in as well
      residue_next     = fold_symbol(r1, cg_times3[4:0]);
      class_group_next = '0;
      group_count_next = 2'd0;
    end else begin
      residue_next     = r1;
      class_group_next = cg_times3[4:0];
      group_count_next = group_count + 2'd1;
    end
  end

  assign push                  = accept & last_char;
  assign push_desc.residue     = residue_next;
  assign push_desc.class_group = class_group_next;
  assign push_desc.flush       = (group_count_next != 2'd0);
  assign push_desc.err         = error_seen_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      residue     <= RESIDUE_INIT;
      class_group <= '0;
      group_count <= 2'd0;
      error_seen  <= 1'b0;
    end else if (accept) begin
      residue     <= residue_next;
      class_group <= class_group_next;
      group_count <= group_count_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

### rtl/dcg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcg_queue
// Two-entry queue of finished descriptors between front and back.
// ----------------------------------------------------------------------------
module dcg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dcg_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output dcg_pkg::desc_t pop_desc
);
  import dcg_pkg::*;

  desc_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign pop_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/dcg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcg_back
// Finishes one descriptor: flushes a partial class group, runs the eight
// zero rounds one a cycle, then emits eight checksum characters.
// ----------------------------------------------------------------------------
module dcg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  dcg_pkg::desc_t pop_desc,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     checksum_char,
  output logic           final_symbol,
  output logic           bad_input
);
  import dcg_pkg::*;

  typedef enum logic [1:0] {BK_IDLE, BK_FOLD, BK_EMIT} bk_state_t;

  bk_state_t           state;
  logic [ResidueW-1:0] r, r_fold;
  logic [SymW-1:0]     cg;
  logic                first, err;
  logic [3:0]          steps;
  logic [2:0]          idx;
  logic                out_free;

  assign pop      = (state == BK_IDLE) & q_valid;
  assign out_free = ~out_valid | ~out_stall;
  assign r_fold   = fold_symbol(r, first ? cg : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new character while emitting, drop valid once taken otherwise
      if (out_free) out_valid <= (state == BK_EMIT);
      case (state)
        BK_IDLE: begin
          if (q_valid) begin
            r     <= pop_desc.residue;
            cg    <= pop_desc.class_group;
            first <= pop_desc.flush;
            err   <= pop_desc.err;
            steps <= pop_desc.flush ? 4'd9 : 4'd8;
            state <= BK_FOLD;
          end
        end
        BK_FOLD: begin
          first <= 1'b0;
          steps <= steps - 4'd1;
          if (steps == 4'd1) begin
            r     <= r_fold ^ RESIDUE_INIT;
            idx   <= 3'd0;
            state <= BK_EMIT;
          end else begin
            r <= r_fold;
          end
        end
        BK_EMIT: begin
          if (out_free) begin
            checksum_char <= OUT_ALPHABET[r[ResidueW-1 -: SymW]];
            final_symbol  <= (idx == 3'd7);
            bad_input     <= err;
            r             <= r << SymW;
            idx           <= idx + 3'd1;
            if (idx == 3'd7) state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

endmodule

### rtl/descriptor_checksum_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_checksum_generator_core
// Output descriptor checksum: eight bech32 characters per descriptor.
// ----------------------------------------------------------------------------
// Input channel: one request per descriptor character (char_code), with
// last_char high on the final one. Characters are taken one a cycle; only a
// final character waits, and only while the two-entry descriptor queue is
// full. A byte outside the input charset is skipped and flags bad_input.
// Output channel: eight requests per descriptor, most significant symbol
// first, final_symbol high on the eighth; bad_input is the same on all eight.
// After the final character is taken it passes the queue and the load step,
// then the polymod rounds one a cycle (a flush round for a partial class
// group, then eight zero rounds), then one checksum character a cycle while not stalled.
// The back end works one descriptor at a time, through its single polymod
// round unit and eight emit steps; the front takes characters meanwhile.
// A stalled output holds its character; the back end waits and the queue
// absorbs up to two finished descriptors.
// Reset restores the running residue, empties the queue and clears out_valid.
// ----------------------------------------------------------------------------
module descriptor_checksum_generator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] checksum_char,
  output logic       final_symbol,
  output logic       bad_input
);
  import dcg_pkg::*;

  logic  push, pop, q_full, q_valid;
  desc_t push_desc, pop_desc;

  dcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  dcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_desc  (pop_desc)
  );

  dcg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .pop_desc      (pop_desc),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .checksum_char (checksum_char),
    .final_symbol  (final_symbol),
    .bad_input     (bad_input)
  );

endmodule
